[rtl/polq_pkg.sv]
// polq_pkg: shared types, sizes and codes of the priority-ordered lock queue
// holds the request and result beat structs, status codes and the priority clamp
// no dependencies
package polq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 16;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W    = 4;
  localparam int REQ_PRIO_W = 16;

  localparam longint PRIO_HI = (longint'(1) <<< (PRIORITY_BITS - 1)) - 1;
  localparam longint PRIO_LO = -PRIO_HI - 1;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_HANDOVER = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  typedef struct packed {
    op_t                           operation;
    logic [ID_W-1:0]               requester;
    logic signed [REQ_PRIO_W-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             grant;
    logic [ID_W-1:0]  new_owner;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]                 id;
    logic signed [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // clamp the request priority into the stored signed range
  function automatic logic signed [PRIORITY_BITS-1:0] sat_prio(
    input logic signed [REQ_PRIO_W-1:0] raw
  );
    longint v;
    v = longint'(raw);
    if (v > PRIO_HI) v = PRIO_HI;
    if (v < PRIO_LO) v = PRIO_LO;
    return PRIORITY_BITS'(v);
  endfunction

endpackage

[rtl/priority_ordered_lock_queue.sv]
// priority_ordered_lock_queue: lock arbiter with a sorted, bounded wait queue
// one wait memory, one priority comparator and a small sequencer
// depends on polq_pkg
//
// One beat on req is taken at a clock edge where start is high and busy is low.
// Every request beat produces exactly one result beat: res is valid while done
// is high, for one cycle only, and the receiver cannot stall it, so it must
// capture res whenever done is seen. A lock on a free lock, a lock that finds
// the queue full, and an unlock with nobody waiting finish at once (done
// in the cycle after the accept, and busy stays low). An unlock that hands the
// lock to the head waiter goes through S_POP, using the head entry read from
// the wait memory at the accept edge. A queued lock walks from the tail of the
// queue toward the head, moving each waiter with a greater priority value up by
// one slot: each such waiter takes a memory read in S_READ, then the shared
// compare and a write in S_CMP. The wait memory needs no clearing after reset:
// only data read from occupied slots is ever used.
module priority_ordered_lock_queue
  import polq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_PLACE = 5'b01000,
    S_POP   = 5'b10000
  } state_t;

  state_t state;

  // lock owner
  logic            owner_valid;
  logic [ID_W-1:0] owner_id;

  // circular wait queue, head holds the next owner
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [COUNT_W-1:0] count;

  // insertion walk
  logic [PTR_W-1:0]   wr_ptr;  // free slot being filled
  logic [COUNT_W-1:0] left;    // waiters still ahead of the new beat

  // captured request
  logic [ID_W-1:0]                 new_id;
  logic signed [PRIORITY_BITS-1:0] new_prio;

  // wait memory
  entry_t           wait_mem [QUEUE_DEPTH];
  entry_t           rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic shift_up;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign busy = (state != S_IDLE);

  // the shared comparator: does the waiter just read sort after the new beat
  assign shift_up = ($signed(rd_data.prio) > $signed(new_prio));

  // idle reads the head so an unlock finds it ready, the walk reads below the hole
  assign rd_addr = (state == S_READ) ? ptr_prev(wr_ptr) : head;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr;
    mem_wdata = '{id: new_id, prio: new_prio};
    if (state == S_PLACE) begin
      mem_we = 1'b1;
    end else if (state == S_CMP) begin
      mem_we = 1'b1;
      if (shift_up) begin
        mem_wdata = rd_data;  // move the waiter up one slot
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wait_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= wait_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      owner_valid <= 1'b0;
      owner_id    <= '0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            new_id   <= req.requester;
            new_prio <= sat_prio(req.priority_req);
            if (req.operation == OP_LOCK) begin
              if (!owner_valid) begin
                // free lock, grant at once
                owner_valid <= 1'b1;
                owner_id    <= req.requester;
                done        <= 1'b1;
                res         <= '{status: ST_GRANTED, grant: 1'b1,
                                 new_owner: req.requester};
              end else if (count == COUNT_W'(QUEUE_DEPTH)) begin
                // no room, drop the beat
                done <= 1'b1;
                res  <= '{status: ST_FULL, grant: 1'b0, new_owner: owner_id};
              end else begin
                wr_ptr <= tail;
                left   <= count;
                state  <= (count == '0) ? S_PLACE : S_READ;
              end
            end else if (count != '0) begin
              state <= S_POP;
            end else begin
              // nobody waits, lock goes free
              owner_valid <= 1'b0;
              owner_id    <= '0;
              done        <= 1'b1;
              res         <= '{status: ST_IDLE, grant: 1'b0, new_owner: '0};
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (shift_up) begin
            wr_ptr <= ptr_prev(wr_ptr);
            left   <= left - COUNT_W'(1);
            state  <= (left == COUNT_W'(1)) ? S_PLACE : S_READ;
          end else begin
            // new beat written into the hole this cycle
            tail  <= ptr_next(tail);
            count <= count + COUNT_W'(1);
            done  <= 1'b1;
            res   <= '{status: ST_QUEUED, grant: 1'b0, new_owner: owner_id};
            state <= S_IDLE;
          end
        end
        S_PLACE: begin
          tail  <= ptr_next(tail);
          count <= count + COUNT_W'(1);
          done  <= 1'b1;
          res   <= '{status: ST_QUEUED, grant: 1'b0, new_owner: owner_id};
          state <= S_IDLE;
        end
        S_POP: begin
          // head entry was read at the accept edge
          owner_valid <= 1'b1;
          owner_id    <= rd_data.id;
          head        <= ptr_next(head);
          count       <= count - COUNT_W'(1);
          done        <= 1'b1;
          res         <= '{status: ST_HANDOVER, grant: 1'b1, new_owner: rd_data.id};
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("wait count above queue depth");

  // an empty queue has its pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  // every multi-cycle beat ends with a result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("sequencer went idle without a result");

  // grant flag follows the status code
  a_grant_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.grant == ((res.status == ST_GRANTED) || (res.status == ST_HANDOVER))))
    else $error("grant flag disagrees with status");

  // a handover or grant leaves the lock held
  a_owner_held: assert property (@(posedge clk) disable iff (rst)
    (done && res.grant) |-> (owner_valid && (owner_id == res.new_owner)))
    else $error("granted owner not recorded");

endmodule

[bench/priority_ordered_lock_queue_tb.sv]
// priority_ordered_lock_queue_tb: self-checking bench for the priority-ordered lock queue
// a clocked driver and monitor around the block, an in-bench arbitration model as predictor
// depends on polq_pkg and priority_ordered_lock_queue
`timescale 1ns / 1ps

module priority_ordered_lock_queue_tb;
  import polq_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // longest queued insert walks the whole wait queue, plus margin
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t res;

  priority_ordered_lock_queue u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .res  (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // arbitration model: lock owner plus a sorted list of waiters
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [ID_W-1:0] id;
    longint          prio;
  } waiter_t;

  bit              lock_held = 1'b0;
  logic [ID_W-1:0] lock_owner = '0;
  waiter_t         waiters[$];

  // request priority limited to the stored signed width
  function automatic longint clamp_prio(input logic signed [REQ_PRIO_W-1:0] raw);
    longint v;
    longint hi;
    longint lo;
    v  = longint'(raw);
    hi = (longint'(1) <<< (PRIORITY_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic res_t arbitrate(input req_t r);
    res_t    o;
    waiter_t w;
    int      pos;
    o = '0;
    if (r.operation == OP_LOCK) begin
      if (!lock_held) begin
        // free lock goes straight to the requester
        lock_held   = 1'b1;
        lock_owner  = r.requester;
        o.status    = ST_GRANTED;
        o.grant     = 1'b1;
        o.new_owner = r.requester;
      end else if (waiters.size() >= QUEUE_DEPTH) begin
        // full queue: request dropped, state untouched
        o.status    = ST_FULL;
        o.new_owner = lock_owner;
      end else begin
        // insert after every waiter with lower or equal priority value
        w.id   = r.requester;
        w.prio = clamp_prio(r.priority_req);
        pos = 0;
        while (pos < waiters.size() && waiters[pos].prio <= w.prio) pos++;
        waiters.insert(pos, w);
        o.status    = ST_QUEUED;
        o.new_owner = lock_owner;
      end
    end else if (waiters.size() != 0) begin
      // unlock hands over to the head waiter, whoever sent it
      w = waiters[0];
      waiters.delete(0);
      lock_held   = 1'b1;
      lock_owner  = w.id;
      o.status    = ST_HANDOVER;
      o.grant     = 1'b1;
      o.new_owner = w.id;
    end else begin
      // nobody waits: lock freed (also when already free)
      lock_held   = 1'b0;
      lock_owner  = '0;
      o.status    = ST_IDLE;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping shared by driver, monitor and sequencer
  // ---------------------------------------------------------------------------
  req_t lock_traffic[$];   // beats waiting to be offered
  res_t owed_verdicts[$];  // predicted results, oldest first
  bit   beat_taken = 1'b0; // set by the monitor when the block takes a beat
  int   idle_pct = 0;      // sender idle chance in the current phase
  int   mismatches = 0;
  int   cycles = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // driver: new beat or idle decided at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_beat
    req_t nxt;
    bit   rest;
    rest = ($urandom_range(0, 99) < idle_pct);
    if (start && !beat_taken) begin
      // beat still on offer, hold it steady
    end else if (lock_traffic.size() != 0 && !rest) begin
      nxt = lock_traffic[0];
      lock_traffic.delete(0);
      req   <= nxt;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
    beat_taken = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: results checked first, then the accepted beat is predicted,
  // so a beat taken at this edge can never match a result seen at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    res_t want;
    if (!rst) begin
      if (done) begin
        if (owed_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: status %0d grant %0b owner %0d",
                                  res.status, res.grant, res.new_owner));
        end else begin
          want = owed_verdicts[0];
          owed_verdicts.delete(0);
          if (res.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
          if (res.grant !== want.grant)
            flag_mismatch($sformatf("grant %0b, want %0b", res.grant, want.grant));
          if (res.new_owner !== want.new_owner)
            flag_mismatch($sformatf("new_owner %0d, want %0d", res.new_owner, want.new_owner));
        end
      end
      if (start && !busy) begin
        owed_verdicts.insert(owed_verdicts.size(), arbitrate(req));
        beat_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("priority_ordered_lock_queue verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_op(input op_t op, input int id, input int prio);
    req_t r;
    r.operation    = op;
    r.requester    = ID_W'(id);
    r.priority_req = REQ_PRIO_W'(prio);
    lock_traffic.insert(lock_traffic.size(), r);
  endtask

  // segments with a lock-heavy, balanced or unlock-heavy mix so the wait
  // queue swings between empty and full
  task automatic add_random_ops(input int n);
    int   seg_left;
    int   lock_pct;
    logic [REQ_PRIO_W-1:0] raw;
    req_t r;
    seg_left = 0;
    lock_pct = 50;
    repeat (n) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       lock_pct = 15;
          1:       lock_pct = 50;
          default: lock_pct = 85;
        endcase
      end
      seg_left--;
      case ($urandom_range(0, 5))
        0, 1: raw = REQ_PRIO_W'($urandom_range(0, 6) - 3);  // ties likely
        2: begin
          case ($urandom_range(0, 3))
            0:       raw = 16'h8000;
            1:       raw = 16'h7fff;
            2:       raw = 16'h0000;
            default: raw = 16'hffff;
          endcase
        end
        default: raw = REQ_PRIO_W'($urandom_range(0, 65535));
      endcase
      r.operation    = ($urandom_range(0, 99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
      r.requester    = ID_W'($urandom_range(0, 15));
      r.priority_req = raw;
      lock_traffic.insert(lock_traffic.size(), r);
    end
  endtask

  // sender holds back until every beat is taken and every result is in
  task automatic wait_quiet();
    while (lock_traffic.size() != 0 || start || owed_verdicts.size() != 0)
      @(posedge clk);
  endtask

  initial begin : sequencer
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // phase one: sender idles about a third of the time
    idle_pct = 32;

    // directed: unlock while free, grant, fill the queue, overflow, drain a bit
    add_op(OP_UNLOCK, 3, 16'h1234);
    add_op(OP_LOCK, 15, 32767);
    add_op(OP_LOCK, 0, 5);
    add_op(OP_LOCK, 1, 5);
    add_op(OP_LOCK, 2, -32768);
    add_op(OP_LOCK, 3, 32767);
    add_op(OP_LOCK, 4, 5);
    add_op(OP_LOCK, 15, 0);        // owner asks again
    add_op(OP_LOCK, 6, -1);
    add_op(OP_LOCK, 7, 1);
    add_op(OP_LOCK, 8, -32768);
    add_op(OP_LOCK, 9, 32767);
    add_op(OP_LOCK, 10, -2);
    add_op(OP_LOCK, 11, 5);
    add_op(OP_LOCK, 12, 100);
    add_op(OP_LOCK, 13, -100);
    add_op(OP_LOCK, 14, 0);
    add_op(OP_LOCK, 5, -32767);
    add_op(OP_LOCK, 9, 0);         // queue full, dropped
    add_op(OP_UNLOCK, 2, 0);       // released by a non-owner
    add_op(OP_UNLOCK, 8, -1);
    add_op(OP_LOCK, 0, 32767);
    add_op(OP_UNLOCK, 0, 0);
    add_random_ops(590);
    wait_quiet();

    // phase two: sender mostly idle
    idle_pct = 88;
    add_random_ops(580);
    wait_quiet();

    // phase three: back to back
    idle_pct = 0;
    add_random_ops(580);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_verdicts.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", owed_verdicts.size()));

    if (mismatches == 0) begin
      $display("priority_ordered_lock_queue verification clean");
    end else begin
      $display("priority_ordered_lock_queue verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/polq_pkg.sv
rtl/priority_ordered_lock_queue.sv
bench/priority_ordered_lock_queue_tb.sv
